/* sv/cpu_execute_stage_alu_branch_unit_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros for the execute stage alu and branch unit
// checks are compiled out when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef CPU_EXECUTE_STAGE_ALU_BRANCH_UNIT_MACROS_SVH
`define CPU_EXECUTE_STAGE_ALU_BRANCH_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CEAB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define CEAB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next cycle check failed");
`else
`define CEAB_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CEAB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* sv/ceab_pkg.sv */
// ---------------------------------------------------------------------------
// ceab_pkg
// types and constants shared by the execute stage alu and branch unit
// ---------------------------------------------------------------------------
`default_nettype none

package ceab_pkg;

  localparam int DataW      = 64;
  localparam int HalfW      = DataW / 2;
  localparam int DivStages  = DataW;
  localparam int MulStages  = 2;
  localparam logic [DataW-1:0] StackOffset = 64'd8;

  typedef enum logic [3:0] {
    FN_ADD  = 4'd0,
    FN_SUB  = 4'd1,
    FN_MUL  = 4'd2,
    FN_DIV  = 4'd3,
    FN_AND  = 4'd4,
    FN_OR   = 4'd5,
    FN_NOT  = 4'd6,
    FN_XOR  = 4'd7,
    FN_SHL  = 4'd8,
    FN_SHR  = 4'd9,
    FN_MOV  = 4'd10,
    FN_BR   = 4'd11,
    FN_BRNZ = 4'd12,
    FN_BRGT = 4'd13,
    FN_RET  = 4'd14,
    FN_HLT  = 4'd15
  } func_t;

  typedef enum logic [1:0] {
    PC_KEEP = 2'd0,
    PC_JUMP = 2'd1,
    PC_LOAD = 2'd2,
    PC_HALT = 2'd3
  } pc_action_t;

  typedef enum logic [1:0] {
    SEL_SIMPLE = 2'd0,
    SEL_MUL    = 2'd1,
    SEL_DIV    = 2'd2
  } sel_t;

  typedef struct packed {
    logic [3:0]       func;
    logic             imm_used;
    logic [DataW-1:0] immediate;
    logic [DataW-1:0] first_value;
    logic [DataW-1:0] second_value;
    logic [DataW-1:0] third_value;
    logic [DataW-1:0] stack_value;
    logic [DataW-1:0] pc;
    logic             add_needed;
    logic             push_return;
  } req_t;

  typedef struct packed {
    logic [1:0]       pc_action;
    logic [DataW-1:0] next_pc;
    logic             result_valid;
    logic [DataW-1:0] result_value;
    logic [DataW-1:0] mem_address;
    logic             mem_write;
    logic [DataW-1:0] store_data;
    logic             div_zero;
  } rsp_t;

  typedef struct packed {
    logic valid;
    sel_t sel;
    rsp_t rsp;
  } side_t;

endpackage

`default_nettype wire

/* sv/ceab_req_if.sv */
// ---------------------------------------------------------------------------
// ceab_req_if
// valid/ready channel carrying one decoded instruction per transaction
// ---------------------------------------------------------------------------
`default_nettype none

interface ceab_req_if;
  logic          valid;
  logic          ready;
  ceab_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/ceab_rsp_if.sv */
// ---------------------------------------------------------------------------
// ceab_rsp_if
// valid/ready channel carrying one execute result per transaction
// ---------------------------------------------------------------------------
`default_nettype none

interface ceab_rsp_if;
  logic          valid;
  logic          ready;
  ceab_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/ceab_mul.sv */
// ---------------------------------------------------------------------------
// ceab_mul
// two stage 64x64 multiplier keeping the low 64 bits of the product
// ---------------------------------------------------------------------------
`default_nettype none

module ceab_mul (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [ceab_pkg::DataW-1:0] a,
  input  wire logic [ceab_pkg::DataW-1:0] b,
  output logic      [ceab_pkg::DataW-1:0] product
);

  localparam int H = ceab_pkg::HalfW;
  localparam int W = ceab_pkg::DataW;

  logic [W-1:0] p_ll;
  logic [H-1:0] p_cross;
  logic [W-1:0] ll_full;
  logic [W-1:0] lh_full;
  logic [W-1:0] hl_full;

  assign ll_full = a[H-1:0] * b[H-1:0];
  assign lh_full = a[H-1:0] * b[W-1:H];
  assign hl_full = a[W-1:H] * b[H-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      p_ll    <= ll_full;
      p_cross <= lh_full[H-1:0] + hl_full[H-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      product <= p_ll + {p_cross, {H{1'b0}}};
    end
  end

endmodule

`default_nettype wire

/* sv/ceab_div.sv */
// ---------------------------------------------------------------------------
// ceab_div
// restoring unsigned divider, one quotient bit per pipeline stage
// ---------------------------------------------------------------------------
`default_nettype none

module ceab_div (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [ceab_pkg::DataW-1:0] dividend,
  input  wire logic [ceab_pkg::DataW-1:0] divisor,
  output logic      [ceab_pkg::DataW-1:0] quotient
);

  localparam int W = ceab_pkg::DataW;
  localparam int N = ceab_pkg::DivStages;

  logic [W-1:0] rem [0:N-1];
  logic [W-1:0] quo [0:N-1];
  logic [W-1:0] dvs [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [W-1:0] r_in;
    logic [W-1:0] q_in;
    logic [W-1:0] d_in;
    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign q_in = dividend;
      assign d_in = divisor;
    end else begin : g_rest
      assign r_in = rem[k-1];
      assign q_in = quo[k-1];
      assign d_in = dvs[k-1];
    end

    assign shifted = {r_in, q_in[W-1]};
    assign ge      = shifted >= {1'b0, d_in};
    assign diff    = shifted - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[W-1:0] : shifted[W-1:0];
        quo[k] <= {q_in[W-2:0], ge};
        dvs[k] <= d_in;
      end
    end
  end

  assign quotient = quo[N-1];

endmodule

`default_nettype wire

/* sv/cpu_execute_stage_alu_branch_unit.sv */
// an accepted request passes the input register, the side line and the output register
// throughput: one transaction per cycle unless stalled; 64-stage divider sets the depth
// every instruction runs the full depth so results leave in order
// a stall at the output freezes the whole pipeline; nothing is dropped or repeated
// reset (rst, synchronous) clears all valid bits and the side line; no other state
// ---------------------------------------------------------------------------
// cpu_execute_stage_alu_branch_unit
// 64-bit alu with branch resolution, fully pipelined
// ---------------------------------------------------------------------------
`default_nettype none

`include "cpu_execute_stage_alu_branch_unit_macros.svh"

module cpu_execute_stage_alu_branch_unit (
  input wire logic clk,
  input wire logic rst,
  ceab_req_if.sink   req,
  ceab_rsp_if.source rsp
);

  localparam int W = ceab_pkg::DataW;
  localparam int N = ceab_pkg::DivStages;
  localparam int M = N - ceab_pkg::MulStages;

  logic            en;
  logic            v0;
  ceab_pkg::req_t  s0;
  ceab_pkg::side_t side_next;
  ceab_pkg::side_t side [0:N-1];
  logic [W-1:0]    mul_line [0:M-1];
  logic [W-1:0]    opnd_b;
  logic [W-1:0]    product;
  logic [W-1:0]    quotient;
  logic            out_valid;
  ceab_pkg::rsp_t  out_data;
  ceab_pkg::rsp_t  out_data_next;

  assign en        = !out_valid || rsp.ready;
  assign req.ready = en;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= req.data;
    end
  end

  assign opnd_b = s0.imm_used ? s0.immediate : s0.second_value;

  always_comb begin
    side_next       = '0;
    side_next.valid = v0;
    side_next.sel   = ceab_pkg::SEL_SIMPLE;
    case (ceab_pkg::func_t'(s0.func))
      ceab_pkg::FN_HLT: begin
        side_next.rsp.pc_action = ceab_pkg::PC_HALT;
      end
      ceab_pkg::FN_RET: begin
        side_next.rsp.pc_action   = ceab_pkg::PC_LOAD;
        side_next.rsp.mem_address = s0.stack_value - ceab_pkg::StackOffset;
      end
      ceab_pkg::FN_BR: begin
        side_next.rsp.pc_action = ceab_pkg::PC_JUMP;
        if (s0.add_needed) begin
          side_next.rsp.next_pc = s0.pc + (s0.imm_used ? s0.immediate : s0.first_value);
        end else begin
          side_next.rsp.next_pc = s0.first_value;
          if (s0.push_return) begin
            side_next.rsp.mem_address = s0.stack_value - ceab_pkg::StackOffset;
            side_next.rsp.mem_write   = 1'b1;
            side_next.rsp.store_data  = s0.pc;
          end
        end
      end
      ceab_pkg::FN_BRNZ: begin
        if (s0.second_value != '0) begin
          side_next.rsp.pc_action = ceab_pkg::PC_JUMP;
          side_next.rsp.next_pc   = s0.first_value;
        end
      end
      ceab_pkg::FN_BRGT: begin
        if ($signed(s0.second_value) > $signed(s0.third_value)) begin
          side_next.rsp.pc_action = ceab_pkg::PC_JUMP;
          side_next.rsp.next_pc   = s0.first_value;
        end
      end
      default: begin
        side_next.rsp.result_valid = 1'b1;
        case (ceab_pkg::func_t'(s0.func))
          ceab_pkg::FN_ADD: side_next.rsp.result_value = s0.first_value + opnd_b;
          ceab_pkg::FN_SUB: side_next.rsp.result_value = s0.first_value - opnd_b;
          ceab_pkg::FN_MUL: side_next.sel = ceab_pkg::SEL_MUL;
          ceab_pkg::FN_DIV: begin
            side_next.sel          = ceab_pkg::SEL_DIV;
            side_next.rsp.div_zero = (opnd_b == '0);
          end
          ceab_pkg::FN_AND: side_next.rsp.result_value = s0.first_value & opnd_b;
          ceab_pkg::FN_OR:  side_next.rsp.result_value = s0.first_value | opnd_b;
          ceab_pkg::FN_NOT: side_next.rsp.result_value = ~s0.first_value;
          ceab_pkg::FN_XOR: side_next.rsp.result_value = s0.first_value ^ opnd_b;
          ceab_pkg::FN_SHL: side_next.rsp.result_value =
            (|opnd_b[W-1:6]) ? '0 : (s0.first_value << opnd_b[5:0]);
          ceab_pkg::FN_SHR: side_next.rsp.result_value =
            (|opnd_b[W-1:6]) ? '0 : (s0.first_value >> opnd_b[5:0]);
          default: side_next.rsp.result_value = opnd_b;
        endcase
      end
    endcase
  end

  ceab_mul u_mul (
    .clk     (clk),
    .en      (en),
    .a       (s0.first_value),
    .b       (opnd_b),
    .product (product)
  );

  ceab_div u_div (
    .clk      (clk),
    .en       (en),
    .dividend (s0.first_value),
    .divisor  (opnd_b),
    .quotient (quotient)
  );

  // side info line, aligned with the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        side[i] <= '0;
      end
    end else if (en) begin
      side[0] <= side_next;
      for (int i = 1; i < N; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // product delay line, aligned with the tail of the side line
  always_ff @(posedge clk) begin
    if (en) begin
      mul_line[0] <= product;
      for (int i = 1; i < M; i++) begin
        mul_line[i] <= mul_line[i-1];
      end
    end
  end

  always_comb begin
    out_data_next = side[N-1].rsp;
    case (side[N-1].sel)
      ceab_pkg::SEL_MUL: out_data_next.result_value = mul_line[M-1];
      ceab_pkg::SEL_DIV: out_data_next.result_value = quotient;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= side[N-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_data_next;
    end
  end

  `CEAB_ASSERT_NEXT(a_accept_enters, clk, rst, req.valid && req.ready, v0)
  `CEAB_ASSERT_IMPLY(a_div_zero_ones, clk, rst, rsp.valid && rsp.data.div_zero,
    rsp.data.result_valid && (rsp.data.result_value == '1))
  `CEAB_ASSERT_IMPLY(a_call_jumps, clk, rst, rsp.valid && rsp.data.mem_write,
    rsp.data.pc_action == ceab_pkg::PC_JUMP)
  `CEAB_ASSERT_NEXT(a_stall_freezes, clk, rst, out_valid && !rsp.ready, out_valid)

endmodule

`default_nettype wire

/* verif/cpu_execute_stage_alu_branch_unit_tb.sv */
// ---------------------------------------------------------------------------
// cpu_execute_stage_alu_branch_unit_tb
// drives decoded instructions into the execute stage and checks every result
// against an in-bench prediction of the alu and branch behavior, with random
// gaps on the request side and random stalls on the result side
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpu_execute_stage_alu_branch_unit_tb;

  localparam int Latency = 65;
  localparam longint CycleLimit = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ceab_req_if req_ch ();
  ceab_rsp_if rsp_ch ();

  cpu_execute_stage_alu_branch_unit u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  always #1 clk = ~clk;

  ceab_pkg::rsp_t exec_expected[$];
  int     mismatches = 0;
  longint cycles = 0;
  bit     sink_busy = 1'b0;
  int     stall_left = 0;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
  end

  function automatic int rand_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      2: w = {1'b1, 63'd0};
      3: w = 64'($urandom_range(0, 70));
      4: w = 64'd0 - 64'($urandom_range(0, 8));
      default: ;
    endcase
    return w;
  endfunction

  function automatic ceab_pkg::rsp_t predict_exec(ceab_pkg::req_t r);
    ceab_pkg::rsp_t o;
    logic [63:0] b;
    o = '0;
    b = r.imm_used ? r.immediate : r.second_value;
    case (ceab_pkg::func_t'(r.func))
      ceab_pkg::FN_HLT: o.pc_action = ceab_pkg::PC_HALT;
      ceab_pkg::FN_RET: begin
        o.pc_action = ceab_pkg::PC_LOAD;
        o.mem_address = r.stack_value - ceab_pkg::StackOffset;
      end
      ceab_pkg::FN_BR: begin
        o.pc_action = ceab_pkg::PC_JUMP;
        if (r.add_needed) begin
          o.next_pc = r.pc + (r.imm_used ? r.immediate : r.first_value);
        end else begin
          o.next_pc = r.first_value;
          if (r.push_return) begin
            o.mem_address = r.stack_value - ceab_pkg::StackOffset;
            o.mem_write = 1'b1;
            o.store_data = r.pc;
          end
        end
      end
      ceab_pkg::FN_BRNZ: if (r.second_value != 0) begin
        o.pc_action = ceab_pkg::PC_JUMP;
        o.next_pc = r.first_value;
      end
      ceab_pkg::FN_BRGT: if ($signed(r.second_value) > $signed(r.third_value)) begin
        o.pc_action = ceab_pkg::PC_JUMP;
        o.next_pc = r.first_value;
      end
      default: begin
        o.result_valid = 1'b1;
        case (ceab_pkg::func_t'(r.func))
          ceab_pkg::FN_ADD: o.result_value = r.first_value + b;
          ceab_pkg::FN_SUB: o.result_value = r.first_value - b;
          ceab_pkg::FN_MUL: o.result_value = r.first_value * b;
          ceab_pkg::FN_DIV: begin
            if (b == 0) begin
              o.result_value = '1;
              o.div_zero = 1'b1;
            end else begin
              o.result_value = r.first_value / b;
            end
          end
          ceab_pkg::FN_AND: o.result_value = r.first_value & b;
          ceab_pkg::FN_OR:  o.result_value = r.first_value | b;
          ceab_pkg::FN_NOT: o.result_value = ~r.first_value;
          ceab_pkg::FN_XOR: o.result_value = r.first_value ^ b;
          ceab_pkg::FN_SHL: o.result_value = (b >= 64) ? '0 : r.first_value << b[5:0];
          ceab_pkg::FN_SHR: o.result_value = (b >= 64) ? '0 : r.first_value >> b[5:0];
          default: o.result_value = b;
        endcase
      end
    endcase
    return o;
  endfunction

  task automatic send_instr(ceab_pkg::req_t r);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    exec_expected.push_back(predict_exec(r));
  endtask

  function automatic ceab_pkg::req_t rand_instr(ceab_pkg::func_t f);
    ceab_pkg::req_t r;
    r.func = f;
    r.imm_used = 1'($urandom_range(0, 1));
    r.immediate = rand_word();
    r.first_value = rand_word();
    r.second_value = rand_word();
    r.third_value = ($urandom_range(0, 3) == 0) ? r.second_value : rand_word();
    r.stack_value = rand_word();
    r.pc = rand_word();
    r.add_needed = 1'($urandom_range(0, 1));
    r.push_return = 1'($urandom_range(0, 1));
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (exec_expected.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected transaction %p", rsp_ch.data);
        end else begin
          ceab_pkg::rsp_t e;
          e = exec_expected.pop_front();
          if (e !== rsp_ch.data) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected %p actual %p", e, rsp_ch.data);
          end
        end
      end
      if (sink_busy) begin
        rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 2) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left <= rand_gap();
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_extremes();
    ceab_pkg::req_t r;
    for (int f = 0; f < 16; f++) begin
      r = rand_instr(ceab_pkg::func_t'(f));
      r.first_value = '1;
      r.second_value = '1;
      r.immediate = {1'b1, 63'd0};
      send_instr(r);
    end
    r = rand_instr(ceab_pkg::FN_DIV); r.imm_used = 1'b0; r.second_value = '0; send_instr(r);
    r = rand_instr(ceab_pkg::FN_SHL); r.imm_used = 1'b1; r.immediate = 64'd64; send_instr(r);
    r = rand_instr(ceab_pkg::FN_SHR); r.imm_used = 1'b0; r.second_value = 64'd63;
    send_instr(r);
    r = rand_instr(ceab_pkg::FN_RET); r.stack_value = '0; send_instr(r);
    r = rand_instr(ceab_pkg::FN_BR); r.add_needed = 1'b0; r.push_return = 1'b1;
    r.stack_value = 64'd4;
    send_instr(r);
    r = rand_instr(ceab_pkg::FN_BR); r.add_needed = 1'b0; r.push_return = 1'b0;
    send_instr(r);
    r = rand_instr(ceab_pkg::FN_BRNZ); r.second_value = '0; send_instr(r);
    r = rand_instr(ceab_pkg::FN_BRGT); r.second_value = 64'd1; r.third_value = '1;
    send_instr(r);
    r = rand_instr(ceab_pkg::FN_BRGT); r.second_value = {1'b1, 63'd0}; r.third_value = '0;
    send_instr(r);
  endtask

  task automatic test_random();
    for (int i = 0; i < 1000; i++)
      send_instr(rand_instr(ceab_pkg::func_t'($urandom_range(0, 15))));
  endtask

  task automatic test_back_to_back();
    sink_busy = 1'b1;
    for (int i = 0; i < 150; i++) begin
      req_ch.valid <= 1'b1;
      req_ch.data <= rand_instr(ceab_pkg::func_t'($urandom_range(0, 15)));
      @(posedge clk);
      while (!req_ch.ready) @(posedge clk);
      exec_expected.push_back(predict_exec(req_ch.data));
    end
    sink_busy = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_back_to_back();
    test_random();
    req_ch.valid <= 1'b0;
    while (exec_expected.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

`default_nettype wire
